FILE: src/nte_pkg.sv
// ============================================================================
// nte_pkg: shared types and constants of the noise threshold estimator
// Widths of the accumulators and the control structs between the sequencer
// and the shared divide / square root unit.
// ============================================================================
`default_nettype none

package nte_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int LEN_W      = 11;   // window length register width
    localparam int COUNT_W    = 10;   // samples held before the closing one
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 27;
    localparam int SUMSQ_W    = 41;
    localparam int SQ_W       = 31;
    localparam int TOTAL_W    = 42;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = 18;
    localparam int SUB_W      = 20;
    localparam int STEP_W     = 6;

    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(TOTAL_W);
    localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_W);

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_ROOT = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

endpackage

`default_nettype wire

FILE: src/nte_iter.sv
// ============================================================================
// nte_iter: shared iterative divide and square root unit
// Restoring division of a 42-bit dividend by an 11-bit divisor, one quotient
// bit per cycle, or a digit-by-digit floor square root of a 32-bit value,
// one root bit per cycle. Both share one subtract-and-compare.
// ============================================================================
`default_nettype none

module nte_iter
    import nte_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire iter_req_t          req,
    input  wire logic [TOTAL_W-1:0] operand,
    input  wire logic [LEN_W-1:0]   divisor,
    output iter_sts_t               sts,
    output logic [TOTAL_W-1:0]      quotient,
    output logic [ROOT_W-1:0]       root
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                op_reg, op_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [LEN_W-1:0]    div_reg, div_next;

    logic [SUB_W-1:0]    op_a, op_b;
    logic [SUB_W:0]      diff;
    logic                ge;

    // The one shared subtractor: divide compares the shifted remainder with
    // the divisor, the root compares it with 4*root + 1.
    always_comb begin
        if (op_reg == OP_ROOT) begin
            op_a = {rem_reg, work_reg[TOTAL_W-1 -: 2]};
            op_b = {2'b00, root_reg, 2'b01};
        end else begin
            op_a = {8'b0, rem_reg[LEN_W-1:0], work_reg[TOTAL_W-1]};
            op_b = {9'b0, div_reg};
        end
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[SUB_W];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        div_next  = div_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = req.op;
            rem_next  = '0;
            root_next = '0;
            div_next  = divisor;
            if (req.op == OP_ROOT) begin
                work_next = {operand[RAD_W-1:0], (TOTAL_W-RAD_W)'(0)};
                cnt_next  = ROOT_STEPS;
            end else begin
                work_next = operand;
                cnt_next  = DIV_STEPS;
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
            if (op_reg == OP_ROOT) begin
                work_next = {work_reg[TOTAL_W-3:0], 2'b00};
                root_next = {root_reg[ROOT_W-2:0], ge};
            end else begin
                work_next = {work_reg[TOTAL_W-2:0], ge};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        div_reg  <= div_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = work_reg;
    assign root     = root_reg;

endmodule

`default_nettype wire

FILE: src/noise_threshold_estimator.sv
// ============================================================================
// noise_threshold_estimator: mean plus two sigma noise threshold
// Collects a window of audio samples and reports mean, deviation and the
// noise level mean + 2 * deviation once per window.
// ============================================================================
// Usage:
// Samples enter on the s_ channel (s_valid / s_ready / s_sample). One result
// item leaves on the m_ channel for every completed window, carrying
// m_noise_level, m_window_mean and m_deviation. The window length is written
// on the cfg_ channel (cfg_valid / cfg_ready / cfg_window_len); cfg_ready is
// always high. A length of zero acts as 1 and lengths above 1024 act as 1024.
// A sample that does not close the window keeps s_ready low after its
// acceptance while it is squared and then accumulated, so the block takes no
// new sample before it is through with the last. The closing sample's result
// item waits on the shared divide / root unit after the sample is accepted:
// two 42-step divisions (mean, then variance) and a 16-step square root, plus
// the multiply and handoff states between them; s_ready returns with it.
// Reset (aresetn low at a clock edge) clears the window, drops any pending
// result item and sets the window length to 1024.
// The result sits in an output register, so the next window's samples are
// accepted while it waits; only if a second window closes before the first
// result is taken does the block hold in its output state.
// ============================================================================
`default_nettype none

module noise_threshold_estimator
    import nte_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_noise_level,
    output logic signed [SAMPLE_W-1:0]      m_window_mean,
    output logic [ROOT_W-1:0]               m_deviation,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [LEN_W-1:0]           cfg_window_len
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_MSTART = 4'd3;
    localparam logic [3:0] ST_MWAIT  = 4'd4;
    localparam logic [3:0] ST_P1     = 4'd5;
    localparam logic [3:0] ST_P2     = 4'd6;
    localparam logic [3:0] ST_P3     = 4'd7;
    localparam logic [3:0] ST_P4     = 4'd8;
    localparam logic [3:0] ST_VSTART = 4'd9;
    localparam logic [3:0] ST_VWAIT  = 4'd10;
    localparam logic [3:0] ST_RSTART = 4'd11;
    localparam logic [3:0] ST_RWAIT  = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;

    logic [3:0]                  state_reg, state_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUMSQ_W-1:0]          sumsq_reg, sumsq_next;
    logic                        m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]            wlen_reg;

    // Datapath registers, no reset needed.
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic [LEN_W-1:0]            n_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic signed [SAMPLE_W-1:0]  mean_reg;
    logic signed [SUM_W-1:0]     nm_reg;
    logic signed [SUM_W:0]       t_reg;
    logic signed [43:0]          p_reg;
    logic [TOTAL_W-1:0]          total_reg;
    logic [ROOT_W-1:0]           dev_reg;
    logic signed [SAMPLE_W-1:0]  noise_out_reg, mean_out_reg;
    logic [ROOT_W-1:0]           dev_out_reg;

    logic [LEN_W-1:0]            eff_len;
    logic                        load_out;
    logic signed [31:0]          sq_full;
    logic [SUM_W-1:0]            abs_sum;
    logic [ROOT_W-1:0]           quot_lo;
    logic signed [SAMPLE_W-1:0]  mean_calc;
    logic signed [SUM_W:0]       nm_full;
    logic signed [43:0]          p_full;
    logic [43:0]                 total_full;
    logic signed [17:0]          noise_sum;
    logic signed [SAMPLE_W-1:0]  noise_sat;

    iter_req_t                   iter_req;
    iter_sts_t                   iter_sts;
    logic [TOTAL_W-1:0]          iter_operand;
    logic [TOTAL_W-1:0]          iter_quot;
    logic [ROOT_W-1:0]           iter_root;

    nte_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (iter_req),
        .operand  (iter_operand),
        .divisor  (n_reg),
        .sts      (iter_sts),
        .quotient (iter_quot),
        .root     (iter_root)
    );

    // Effective window length: zero acts as one, large values clamp.
    always_comb begin
        if (wlen_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (wlen_reg > LEN_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = wlen_reg;
        end
    end

    // Arithmetic between the sequencer's registers. The squared deviation
    // total uses sumsq - mean * (2 * sum - n * mean), which equals the exact
    // identity sumsq - 2 * mean * sum + n * mean^2.
    always_comb begin
        sq_full    = x_reg * x_reg;
        abs_sum    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        quot_lo    = iter_quot[ROOT_W-1:0];
        mean_calc  = sum_reg[SUM_W-1] ? SAMPLE_W'(-quot_lo) : SAMPLE_W'(quot_lo);
        nm_full    = $signed({1'b0, n_reg}) * mean_reg;
        p_full     = mean_reg * t_reg;
        total_full = {3'b000, sumsq_reg} - p_reg;
        noise_sum  = {{2{mean_reg[SAMPLE_W-1]}}, mean_reg} + $signed({1'b0, dev_reg, 1'b0});
        if (!noise_sum[17] && noise_sum[16:15] != 2'b00) begin
            noise_sat = 16'sh7FFF;
        end else if (noise_sum[17] && noise_sum[16:15] != 2'b11) begin
            noise_sat = -16'sh8000;
        end else begin
            noise_sat = noise_sum[15:0];
        end
    end

    // Operand for the shared unit depends on which job is being started.
    always_comb begin
        unique case (state_reg)
            ST_VSTART: iter_operand = total_reg;
            ST_RSTART: iter_operand = {(TOTAL_W-RAD_W)'(0), iter_quot[RAD_W-1:0]};
            default:   iter_operand = {(TOTAL_W-SUM_W)'(0), abs_sum};
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        iter_req     = '0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                sum_next   = sum_reg + {{(SUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
                sumsq_next = sumsq_reg + {(SUMSQ_W-SQ_W)'(0), sq_reg};
                if (n_reg < eff_len) begin
                    count_next = n_reg[COUNT_W-1:0];
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV;
                state_next     = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (iter_sts.done) begin
                    state_next = ST_P1;
                end
            end
            ST_P1: state_next = ST_P2;
            ST_P2: state_next = ST_P3;
            ST_P3: state_next = ST_P4;
            ST_P4: state_next = ST_VSTART;
            ST_VSTART: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_DIV;
                state_next     = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (iter_sts.done) begin
                    state_next = ST_RSTART;
                end
            end
            ST_RSTART: begin
                iter_req.start = 1'b1;
                iter_req.op    = OP_ROOT;
                state_next     = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (iter_sts.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait only while an earlier result item is still unclaimed.
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    sum_next     = '0;
                    sumsq_next   = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            m_valid_reg <= 1'b0;
            wlen_reg    <= LEN_W'(MAX_WINDOW);
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sumsq_reg   <= sumsq_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                wlen_reg <= cfg_window_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample;
            n_reg <= {1'b0, count_reg} + LEN_W'(1);
        end
        if (state_reg == ST_SQ) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (state_reg == ST_MWAIT && iter_sts.done) begin
            mean_reg <= mean_calc;
        end
        if (state_reg == ST_P1) begin
            nm_reg <= nm_full[SUM_W-1:0];
        end
        if (state_reg == ST_P2) begin
            t_reg <= {sum_reg[SUM_W-1], sum_reg} + {sum_reg[SUM_W-1], sum_reg}
                     - {nm_reg[SUM_W-1], nm_reg};
        end
        if (state_reg == ST_P3) begin
            p_reg <= p_full;
        end
        if (state_reg == ST_P4) begin
            total_reg <= total_full[TOTAL_W-1:0];
        end
        if (state_reg == ST_RWAIT && iter_sts.done) begin
            dev_reg <= iter_root;
        end
        if (load_out) begin
            noise_out_reg <= noise_sat;
            mean_out_reg  <= mean_reg;
            dev_out_reg   <= dev_reg;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_noise_level = noise_out_reg;
    assign m_window_mean = mean_out_reg;
    assign m_deviation   = dev_out_reg;

    // The sample being added never takes the window past the maximum length,
    // even when the length was lowered below the samples already held.
    a_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ) |-> (n_reg != '0 && n_reg <= LEN_W'(MAX_WINDOW)))
        else $error("window count exceeded the maximum window length");

    // The shared unit only finishes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_sts.done |-> (state_reg == ST_MWAIT || state_reg == ST_VWAIT
                           || state_reg == ST_RWAIT))
        else $error("shared unit finished outside a wait state");

    // A new result item only comes from the output state, and the
    // accumulators are clear afterward.
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (sum_reg == '0 && sumsq_reg == '0 && count_reg == '0 && m_valid))
        else $error("window not cleared after result");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> ($past(state_reg) == ST_OUT))
        else $error("result item raised outside the output state");

endmodule

`default_nettype wire
